// File: rtl/slpcp_pkg.sv
// ----------------------------------------------------------------------------
// slpcp_pkg
// Shared types, character codes and reset values for the serial line
// period command parser.
// ----------------------------------------------------------------------------
package slpcp_pkg;

	localparam int VALUE_BITS_DEF = 20;
	localparam int CFG_INDEX_BITS = 2;
	localparam int COUNT_BITS     = 7;

	localparam logic [7:0] CHAR_NEWLINE = 8'd10;
	localparam logic [7:0] CHAR_MINUS   = 8'd45;
	localparam logic [7:0] CHAR_ZERO    = 8'd48;
	localparam logic [7:0] CHAR_NINE    = 8'd57;
	localparam logic [7:0] CHAR_NUL     = 8'd0;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX     = 7'd127;
	localparam logic [COUNT_BITS-1:0] KEYWORD_LEN   = 7'd3;

	localparam logic [CFG_INDEX_BITS-1:0] REG_LOWER_BOUND = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_UPPER_BOUND = 2'd1;

	localparam int LOWER_BOUND_RESET = 1;
	localparam int UPPER_BOUND_RESET = 1000000;
	localparam int PERIOD_RESET      = 1000;
	localparam int RELOAD_RESET      = 999;

	typedef struct packed {
		logic                  negative;
		logic                  invalid;
		logic                  keyword_ok;
		logic [COUNT_BITS-1:0] count;
	} line_flags_t;

	localparam line_flags_t LINE_FLAGS_CLEAR = '{
		negative:   1'b0,
		invalid:    1'b0,
		keyword_ok: 1'b1,
		count:      '0
	};

	function automatic logic [7:0] keyword_char(input logic [1:0] pos);
		logic [7:0] c;
		case (pos)
			2'd0:    c = 8'd108;
			2'd1:    c = 8'd111;
			2'd2:    c = 8'd103;
			default: c = 8'd0;
		endcase
		return c;
	endfunction

endpackage

// File: rtl/slpcp_line_next.sv
// ----------------------------------------------------------------------------
// slpcp_line_next
// Next line state for one non-newline character: clears a finished line,
// accumulates the decimal magnitude with saturation, tracks sign, invalid
// characters, character count and the keyword match.
// ----------------------------------------------------------------------------
module slpcp_line_next #(
	parameter int VALUE_BITS = slpcp_pkg::VALUE_BITS_DEF
) (
	input  logic [7:0]              rx_byte,
	input  logic                    line_done,
	input  logic [VALUE_BITS-1:0]   mag,
	input  slpcp_pkg::line_flags_t  flags,
	output logic [VALUE_BITS-1:0]   mag_next,
	output slpcp_pkg::line_flags_t  flags_next
);
	import slpcp_pkg::*;

	logic [VALUE_BITS-1:0] base_mag;
	line_flags_t           base_flags;
	logic [VALUE_BITS+3:0] mag_ext;
	logic [VALUE_BITS+3:0] prod;
	logic                  is_digit;

	always_comb begin
		base_mag   = line_done ? '0 : mag;
		base_flags = line_done ? LINE_FLAGS_CLEAR : flags;
		is_digit   = (rx_byte inside {[CHAR_ZERO:CHAR_NINE]});
		mag_ext    = {4'b0, base_mag};
		prod       = (mag_ext << 3) + (mag_ext << 1)
			+ {{(VALUE_BITS-4){1'b0}}, rx_byte - CHAR_ZERO};

		mag_next   = base_mag;
		flags_next = base_flags;

		if (rx_byte != CHAR_NUL) begin
			if (base_flags.count < KEYWORD_LEN) begin
				if (rx_byte != keyword_char(base_flags.count[1:0])) begin
					flags_next.keyword_ok = 1'b0;
				end
			end else begin
				flags_next.keyword_ok = 1'b0;
			end

			if (rx_byte == CHAR_MINUS) begin
				if (base_flags.count == '0) begin
					flags_next.negative = 1'b1;
				end else begin
					flags_next.invalid = 1'b1;
				end
			end else if (is_digit) begin
				if (prod[VALUE_BITS+3:VALUE_BITS] != 4'd0) begin
					mag_next = '1;
				end else begin
					mag_next = prod[VALUE_BITS-1:0];
				end
			end else begin
				flags_next.invalid = 1'b1;
			end

			if (base_flags.count < COUNT_MAX) begin
				flags_next.count = base_flags.count + 1'b1;
			end
		end
	end

endmodule

// File: rtl/serial_line_period_command_parser_unit.sv
// ----------------------------------------------------------------------------
// serial_line_period_command_parser_unit
// Parses newline-terminated command lines from a byte stream into a log
// mode toggle or a timer period, with bounded reload update.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, rx_byte) takes one received byte per
//   transaction, one per cycle while no result stalls. Bytes other than
//   newline update the line state and give no result. A newline gives one
//   result transaction on the output channel (out_valid/out_ready) with
//   log_mode, was_keyword, parsed_period, reload_applied and timer_reload.
//   Latency: the result is valid the cycle after the newline is accepted.
//   Throughput: one byte per cycle while no result stalls; the line state
//   updates in a single pass of logic between its registers and the output
//   register. A stalled result holds the output register; in_ready stays
//   high while the output register is empty or being drained, so the next
//   byte is taken in the same cycle a pending result leaves.
//   Bounds are written through the cfg channel (index 0 lower, 1 upper),
//   always ready. Reset clears the line, sets the period to 1000, the
//   reload to 999 and the bounds to 1 and 1000000.
// ----------------------------------------------------------------------------
module serial_line_period_command_parser_unit #(
	parameter int VALUE_BITS = slpcp_pkg::VALUE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [slpcp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [VALUE_BITS-1:0]                cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [7:0]                           rx_byte,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 log_mode,
	output logic                                 was_keyword,
	output logic signed [VALUE_BITS:0]           parsed_period,
	output logic                                 reload_applied,
	output logic [VALUE_BITS-1:0]                timer_reload
);
	import slpcp_pkg::*;

	logic [VALUE_BITS-1:0]  lower_q;
	logic [VALUE_BITS-1:0]  upper_q;
	logic [VALUE_BITS-1:0]  mag_q;
	line_flags_t            flags_q;
	logic                   line_done_q;
	logic                   log_q;
	logic signed [VALUE_BITS:0] period_q;
	logic [VALUE_BITS-1:0]  reload_q;

	logic                   out_valid_q;
	logic                   keyword_out_q;
	logic                   applied_out_q;

	logic [VALUE_BITS-1:0]  mag_next;
	line_flags_t            flags_next;
	logic                   in_take;
	logic                   is_newline;
	logic                   keyword;
	logic                   applied;
	logic signed [VALUE_BITS:0] period_new;

	slpcp_line_next #(
		.VALUE_BITS (VALUE_BITS)
	) u_line_next (
		.rx_byte    (rx_byte),
		.line_done  (line_done_q),
		.mag        (mag_q),
		.flags      (flags_q),
		.mag_next   (mag_next),
		.flags_next (flags_next)
	);

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign in_take   = in_valid && in_ready;
	assign is_newline = (rx_byte == CHAR_NEWLINE);

	always_comb begin
		keyword = flags_q.keyword_ok && (flags_q.count == KEYWORD_LEN);
		if (flags_q.invalid) begin
			period_new = '1;
		end else if (flags_q.negative) begin
			period_new = -$signed({1'b0, mag_q});
		end else begin
			period_new = $signed({1'b0, mag_q});
		end
		applied = !keyword && !flags_q.invalid && !flags_q.negative
			&& (mag_q > lower_q) && (mag_q < upper_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= VALUE_BITS'(LOWER_BOUND_RESET);
			upper_q <= VALUE_BITS'(UPPER_BOUND_RESET);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LOWER_BOUND: lower_q <= cfg_data;
				REG_UPPER_BOUND: upper_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_q       <= '0;
			flags_q     <= LINE_FLAGS_CLEAR;
			line_done_q <= 1'b0;
			log_q       <= 1'b0;
			period_q    <= (VALUE_BITS+1)'(PERIOD_RESET);
			reload_q    <= VALUE_BITS'(RELOAD_RESET);
		end else if (in_take) begin
			if (is_newline) begin
				line_done_q <= 1'b1;
				if (keyword) begin
					log_q <= !log_q;
				end else begin
					period_q <= period_new;
				end
				if (applied) begin
					reload_q <= mag_q - 1'b1;
				end
			end else begin
				mag_q       <= mag_next;
				flags_q     <= flags_next;
				line_done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			keyword_out_q <= 1'b0;
			applied_out_q <= 1'b0;
		end else if (in_take && is_newline) begin
			out_valid_q   <= 1'b1;
			keyword_out_q <= keyword;
			applied_out_q <= applied;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// log mode, period and reload only change on a newline, so the live
	// registers double as the held result payload
	assign out_valid      = out_valid_q;
	assign log_mode       = log_q;
	assign was_keyword    = keyword_out_q;
	assign parsed_period  = period_q;
	assign reload_applied = applied_out_q;
	assign timer_reload   = reload_q;

	a_newline_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (rx_byte == CHAR_NEWLINE) |=> out_valid)
		else $error("newline transaction gave no result");

	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (rx_byte != CHAR_NEWLINE) && !(out_valid && !out_ready)
		|=> !out_valid)
		else $error("result without newline");

	a_reload_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reload_applied
		|-> (timer_reload == parsed_period[VALUE_BITS-1:0] - 1'b1))
		else $error("applied reload differs from period minus one");

	a_keyword_no_reload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && was_keyword |-> !reload_applied)
		else $error("keyword line applied a reload");

endmodule
